/* hw/rtl/tpig_pkg.sv */
package tpig_pkg;

  localparam int MAX_RANK    = 4;
  localparam int LENGTH_BITS = 12;
  // A padded length can reach three times the largest input length.
  localparam int COORD_W     = LENGTH_BITS + 2;
  localparam int DIM_W       = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int INDEX_W     = 48;
  localparam int PACK_W      = 48;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int MODE_W      = 2;
  localparam int RANK_W      = 3;

  localparam logic [MODE_W-1:0] PAD_CONSTANT  = 2'd0;
  localparam logic [MODE_W-1:0] PAD_REFLECT   = 2'd1;
  localparam logic [MODE_W-1:0] PAD_SYMMETRIC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TENSOR_RANK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTHS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_PADS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PADS    = 3'd4;

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(MAX_RANK);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_MAC
  } state_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             emit;
    logic [DIM_W-1:0] dim;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
  } dp_status_t;

endpackage

/* hw/rtl/tensor_pad_index_generator.sv */
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_restart
// out_     output     out_valid/out_stall out_source_index, out_use_pad_value, out_last_element
// cfg_     input      cfg_we             cfg_index, cfg_data
//
// An item is taken in an accept step, then gets one multiply-add per dimension in
// the shared 48 x 12 bit index multiplier; no new item is taken until it is emitted.
// An item whose padded tensor is empty is taken and gives no result.
// Reset (rst_n, synchronous) loads the register defaults and zeroes the coordinates.
// The final multiply-add waits while the output register holds an untaken item.
module tensor_pad_index_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tpig_pkg::INDEX_W-1:0]   out_source_index,
  output logic                           out_use_pad_value,
  output logic                           out_last_element,
  input  logic                           cfg_we,
  input  logic [tpig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpig_pkg::CFG_W-1:0]     cfg_data
);

  tpig_pkg::dp_cmd_t    cmd;
  tpig_pkg::dp_status_t status;

  tpig_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tpig_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_restart        (in_restart),
    .cmd               (cmd),
    .status            (status),
    .out_source_index  (out_source_index),
    .out_use_pad_value (out_use_pad_value),
    .out_last_element  (out_last_element)
  );

endmodule

/* hw/rtl/tpig_ctrl.sv */
module tpig_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tpig_pkg::dp_status_t status,
  output tpig_pkg::dp_cmd_t    cmd
);

  tpig_pkg::state_t               state_r, state_nxt;
  logic [tpig_pkg::DIM_W-1:0]     dim_r, dim_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_free;
  logic                           last_dim;

  assign out_free = !out_valid_r || !out_stall;
  assign last_dim = (dim_r == tpig_pkg::DIM_W'(tpig_pkg::MAX_RANK - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpig_pkg::ST_IDLE: begin
        if (in_valid && !status.empty) state_nxt = tpig_pkg::ST_MAC;
      end
      tpig_pkg::ST_MAC: begin
        if (last_dim && out_free) state_nxt = tpig_pkg::ST_IDLE;
      end
      default: state_nxt = tpig_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.dim  = dim_r;
    in_stall = 1'b1;
    dim_nxt  = dim_r;
    case (state_r)
      tpig_pkg::ST_IDLE: begin
        // No item is taken while reset is held.
        in_stall = !rst_n;
        cmd.load = in_valid && rst_n;
        dim_nxt  = '0;
      end
      tpig_pkg::ST_MAC: begin
        if (!last_dim) begin
          cmd.step = 1'b1;
          dim_nxt  = dim_r + tpig_pkg::DIM_W'(1);
        end else begin
          // The final multiply-add lands straight in the output register.
          cmd.emit = out_free;
        end
      end
      default: begin
        dim_nxt = '0;
      end
    endcase
    out_valid_nxt = cmd.emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpig_pkg::ST_IDLE;
      dim_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dim_r       <= dim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/tpig_datapath.sv */
module tpig_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tpig_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpig_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_restart,
  input  tpig_pkg::dp_cmd_t                 cmd,
  output tpig_pkg::dp_status_t              status,
  output logic [tpig_pkg::INDEX_W-1:0]      out_source_index,
  output logic                              out_use_pad_value,
  output logic                              out_last_element
);

  localparam int LB = tpig_pkg::LENGTH_BITS;
  localparam int CW = tpig_pkg::COORD_W;
  localparam int IW = tpig_pkg::INDEX_W;
  localparam int MR = tpig_pkg::MAX_RANK;

  logic [tpig_pkg::MODE_W-1:0] mode_r;
  logic [tpig_pkg::RANK_W-1:0] rank_r;
  logic [tpig_pkg::PACK_W-1:0] lengths_r;
  logic [tpig_pkg::PACK_W-1:0] lpads_r;
  logic [tpig_pkg::PACK_W-1:0] rpads_r;

  logic [CW-1:0] coord_r   [MR];
  logic [CW-1:0] coord_nxt [MR];

  logic [IW-1:0] acc_r;
  logic          pad_r;
  logic [IW-1:0] out_index_r;
  logic          out_pad_r;
  logic          out_last_r;

  logic          mirror;
  logic          off;
  logic [tpig_pkg::RANK_W-1:0] rank_eff;
  logic [LB-1:0] len_d  [MR];
  logic [LB-1:0] pl_d   [MR];
  logic [CW-1:0] olen_d [MR];
  logic          empty;
  logic          stale;
  logic          last_now;

  logic [CW-1:0] o_x, p_x, l_x, off_x, src_x;
  logic          pad_now;
  logic [LB-1:0] len_sel;
  logic [IW-1:0] prod;
  logic [IW-1:0] step_val;
  logic          pad_all;

  assign mirror = (mode_r == tpig_pkg::PAD_REFLECT) || (mode_r == tpig_pkg::PAD_SYMMETRIC);
  assign off    = (mode_r == tpig_pkg::PAD_REFLECT);

  always_comb begin
    rank_eff = rank_r;
    if (rank_r == '0) rank_eff = tpig_pkg::RANK_W'(1);
    if (rank_r > tpig_pkg::RANK_W'(MR)) rank_eff = tpig_pkg::RANK_W'(MR);
  end

  // Per-dimension lengths; slots outside the rank are length one with no padding.
  always_comb begin
    logic [LB-1:0] l, a, b, lim;
    empty = 1'b0;
    for (int d = 0; d < MR; d++) begin
      l   = LB'(1);
      a   = '0;
      b   = '0;
      lim = '0;
      if (int'(rank_eff) + d >= MR) begin
        l = lengths_r[(MR-1-d)*LB +: LB];
        a = lpads_r[(MR-1-d)*LB +: LB];
        b = rpads_r[(MR-1-d)*LB +: LB];
        if (mirror) begin
          lim = (l > LB'(off)) ? l - LB'(off) : '0;
          if (a > lim) a = lim;
          if (b > lim) b = lim;
        end
      end
      len_d[d]  = l;
      pl_d[d]   = a;
      olen_d[d] = CW'(l) + CW'(a) + CW'(b);
      if (olen_d[d] == '0) empty = 1'b1;
    end
  end

  always_comb begin
    stale    = 1'b0;
    last_now = 1'b1;
    for (int d = 0; d < MR; d++) begin
      if (coord_r[d] >= olen_d[d]) stale = 1'b1;
      if (coord_r[d] + CW'(1) != olen_d[d]) last_now = 1'b0;
    end
  end

  assign status.empty = empty;

  // Mapping of the selected dimension's output coordinate back to the input.
  always_comb begin
    o_x     = coord_r[cmd.dim];
    p_x     = CW'(pl_d[cmd.dim]);
    l_x     = CW'(len_d[cmd.dim]);
    off_x   = CW'(off);
    pad_now = 1'b0;
    src_x   = '0;
    if (o_x < p_x) begin
      if (!mirror) pad_now = 1'b1;
      else src_x = p_x + off_x - CW'(1) - o_x;
    end else if (o_x - p_x < l_x) begin
      src_x = o_x - p_x;
    end else begin
      if (!mirror) pad_now = 1'b1;
      else src_x = l_x - CW'(1) - off_x - (o_x - p_x - l_x);
    end
  end

  // Horner form, outermost dimension first: acc = acc * len + src.
  assign len_sel  = len_d[cmd.dim];
  assign prod     = acc_r * IW'(len_sel);
  assign step_val = prod + IW'(src_x);
  assign pad_all  = pad_r || pad_now;

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int d = MR - 1; d >= 0; d--) begin
      coord_nxt[d] = coord_r[d];
      if (carry) begin
        if (coord_r[d] + CW'(1) < olen_d[d]) begin
          coord_nxt[d] = coord_r[d] + CW'(1);
          carry        = 1'b0;
        end else begin
          coord_nxt[d] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tpig_pkg::PAD_CONSTANT;
      rank_r    <= tpig_pkg::RANK_RESET;
      lengths_r <= '0;
      lpads_r   <= '0;
      rpads_r   <= '0;
      for (int d = 0; d < MR; d++) coord_r[d] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpig_pkg::REG_PAD_MODE:      mode_r    <= cfg_data[tpig_pkg::MODE_W-1:0];
          tpig_pkg::REG_TENSOR_RANK:   rank_r    <= cfg_data[tpig_pkg::RANK_W-1:0];
          tpig_pkg::REG_INPUT_LENGTHS: lengths_r <= cfg_data[tpig_pkg::PACK_W-1:0];
          tpig_pkg::REG_LEFT_PADS:     lpads_r   <= cfg_data[tpig_pkg::PACK_W-1:0];
          tpig_pkg::REG_RIGHT_PADS:    rpads_r   <= cfg_data[tpig_pkg::PACK_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load && (in_restart || empty || stale)) begin
        for (int d = 0; d < MR; d++) coord_r[d] <= '0;
      end else if (cmd.emit) begin
        for (int d = 0; d < MR; d++) coord_r[d] <= coord_nxt[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
      pad_r <= 1'b0;
    end else if (cmd.step) begin
      acc_r <= step_val;
      pad_r <= pad_all;
    end
    if (cmd.emit) begin
      out_index_r <= pad_all ? '0 : step_val;
      out_pad_r   <= pad_all;
      out_last_r  <= last_now;
    end
  end

  assign out_source_index  = out_index_r;
  assign out_use_pad_value = out_pad_r;
  assign out_last_element  = out_last_r;

endmodule
